@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/tstc_pkg.sv @@
// ----------------------------------------------------------------------------
// tstc_pkg
// Widths, register indexes, constants and interface types of the tick clock.
// ----------------------------------------------------------------------------
package tstc_pkg;

	// field widths
	localparam int DIVIDEND_WIDTH        = 64;
	localparam int DIVISOR_WIDTH         = 32;
	localparam int TPU_WIDTH             = 13;
	localparam int START_WIDTH           = 40;
	localparam int USEC_WIDTH            = 20;
	localparam int DEFAULT_SECONDS_WIDTH = 40;

	// configuration port
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 40;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICKS_PER_SEC  = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TICKS_PER_USEC = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_START_SECONDS  = 2'd2;

	// register reset values
	localparam logic [DIVISOR_WIDTH-1:0] TPS_RESET = 32'd1000000;
	localparam logic [TPU_WIDTH-1:0]     TPU_RESET = 13'd1;

	// divider step counts
	localparam int STEP_CNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);
	localparam logic [STEP_CNT_WIDTH-1:0] STEPS_FULL = STEP_CNT_WIDTH'(DIVIDEND_WIDTH);
	localparam logic [STEP_CNT_WIDTH-1:0] STEPS_HALF = STEP_CNT_WIDTH'(DIVISOR_WIDTH);

	// microsecond arithmetic: low quotient bits kept, anything above saturates
	localparam int USEC_LO_WIDTH  = USEC_WIDTH + 1;
	localparam int USEC_SUM_WIDTH = USEC_WIDTH + 2;
	localparam logic [USEC_SUM_WIDTH-1:0] USEC_PER_SEC = 22'd1000000;
	localparam logic [USEC_WIDTH-1:0]     USEC_LAST    = 20'd999999;

	// divider control and status
	typedef struct packed {
		logic                      start;
		logic [STEP_CNT_WIDTH-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

@@ rtl/tick_to_seconds_microseconds_clock_core.sv @@
// ----------------------------------------------------------------------------
// tick_to_seconds_microseconds_clock_core
// Turns free-running tick counter readings into a seconds/microseconds clock.
// ----------------------------------------------------------------------------
// Each input transaction is one time query carrying a 64-bit tick reading and
// returns one result transaction with seconds and microseconds. The first
// query after reset latches the base and loads seconds from start_seconds; its
// result is published without a division. Later queries divide the tick
// delta by ticks_per_second and the remainder by ticks_per_microsecond on a
// single shared restoring divider that resolves one quotient bit per cycle:
// 64 steps for the first division and 32 for the second. A zero divisor
// register skips its division (with ticks_per_second zero the delta itself
// goes to ticks_per_microsecond, in 64 steps). One query is in flight at a
// time; a new query is accepted the cycle after the result is registered,
// even if that result has not yet been taken.
// Configuration writes are taken at any time and must only be issued while no
// query is in flight.
`include "assert_macros.svh"

module tick_to_seconds_microseconds_clock_core
	import tstc_pkg::*;
#(
	parameter int SECONDS_WIDTH = DEFAULT_SECONDS_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
	// query channel
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [DIVIDEND_WIDTH-1:0]  tick_reading,
	// result channel
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [SECONDS_WIDTH-1:0]   seconds,
	output logic [USEC_WIDTH-1:0]      microseconds
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SETUP = 7'b0000010,
		ST_DIV1  = 7'b0000100,
		ST_DIV2  = 7'b0001000,
		ST_ACC   = 7'b0010000,
		ST_SEC   = 7'b0100000,
		ST_PUB   = 7'b1000000
	} state_t;

	state_t                     state_q;
	logic [DIVISOR_WIDTH-1:0]   tps_q;
	logic [TPU_WIDTH-1:0]       tpu_q;
	logic [START_WIDTH-1:0]     start_q;
	logic                       base_latched_q;
	logic [DIVIDEND_WIDTH-1:0]  last_tick_q;
	logic [DIVIDEND_WIDTH-1:0]  delta_q;
	logic [SECONDS_WIDTH-1:0]   second_count_q;
	logic [USEC_WIDTH-1:0]      microsecond_count_q;
	logic [SECONDS_WIDTH-1:0]   whole_q;
	logic                       usec_big_q;
	logic [USEC_LO_WIDTH-1:0]   usec_lo_q;
	logic                       carry_q;
	logic                       out_valid_q;
	logic [SECONDS_WIDTH-1:0]   seconds_q;
	logic [USEC_WIDTH-1:0]      microseconds_q;

	logic                       in_fire;
	logic                       out_free;
	logic                       tps_zero;
	logic                       tpu_zero;
	div_req_t                   div_req;
	div_sts_t                   div_sts;
	logic [DIVIDEND_WIDTH-1:0]  div_dividend;
	logic [DIVISOR_WIDTH-1:0]   div_divisor;
	logic [DIVIDEND_WIDTH-1:0]  div_quotient;
	logic [DIVISOR_WIDTH-1:0]   div_remainder;
	logic [USEC_SUM_WIDTH-1:0]  usum;
	logic [USEC_SUM_WIDTH-1:0]  usum_wrapped;
	logic                       usec_over;
	logic                       usec_sat;
	logic [USEC_WIDTH-1:0]      usec_next;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign tps_zero  = (tps_q == '0);
	assign tpu_zero  = (tpu_q == '0);

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q   <= TPS_RESET;
			tpu_q   <= TPU_RESET;
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TICKS_PER_SEC:  tps_q   <= cfg_data[DIVISOR_WIDTH-1:0];
				REG_TICKS_PER_USEC: tpu_q   <= cfg_data[TPU_WIDTH-1:0];
				REG_START_SECONDS:  start_q <= cfg_data[START_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// divider request: seconds pass, then microsecond pass
	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = STEPS_FULL;
		div_dividend  = delta_q;
		div_divisor   = tps_q;
		case (state_q)
			ST_SETUP: begin
				if (!tps_zero) begin
					div_req.start = 1'b1;
				end else if (!tpu_zero) begin
					div_req.start = 1'b1;
					div_divisor   = DIVISOR_WIDTH'(tpu_q);
				end
			end
			ST_DIV1: begin
				if (div_sts.done && !tpu_zero) begin
					div_req.start = 1'b1;
					div_req.steps = STEPS_HALF;
					div_dividend  = {div_remainder, {DIVISOR_WIDTH{1'b0}}};
					div_divisor   = DIVISOR_WIDTH'(tpu_q);
				end
			end
			default: ;
		endcase
	end

	tstc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (div_req),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.sts       (div_sts),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	// microsecond accumulate with one carry, saturating at the last microsecond
	always_comb begin
		usum         = USEC_SUM_WIDTH'(microsecond_count_q) + USEC_SUM_WIDTH'(usec_lo_q);
		usum_wrapped = usum - USEC_PER_SEC;
		usec_over    = usec_big_q || (usum >= USEC_PER_SEC);
		usec_sat     = usec_big_q || (usum_wrapped >= USEC_PER_SEC);
		if (!usec_over) begin
			usec_next = usum[USEC_WIDTH-1:0];
		end else if (usec_sat) begin
			usec_next = USEC_LAST;
		end else begin
			usec_next = usum_wrapped[USEC_WIDTH-1:0];
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			base_latched_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// a publishing cycle refills the result register itself
			if (out_valid_q && out_ready && state_q != ST_PUB) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						base_latched_q <= 1'b1;
						state_q        <= base_latched_q ? ST_SETUP : ST_PUB;
					end
				end
				ST_SETUP: begin
					if (!tps_zero) begin
						state_q <= ST_DIV1;
					end else if (!tpu_zero) begin
						state_q <= ST_DIV2;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_DIV1: begin
					if (div_sts.done) begin
						state_q <= tpu_zero ? ST_ACC : ST_DIV2;
					end
				end
				ST_DIV2: begin
					if (div_sts.done) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					state_q <= ST_SEC;
				end
				ST_SEC: begin
					state_q <= ST_PUB;
				end
				ST_PUB: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// clock state and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tick_q         <= '0;
			second_count_q      <= '0;
			microsecond_count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						last_tick_q <= tick_reading;
						if (!base_latched_q) begin
							second_count_q      <= SECONDS_WIDTH'(start_q);
							microsecond_count_q <= '0;
						end
					end
				end
				ST_ACC: begin
					microsecond_count_q <= usec_next;
				end
				ST_SEC: begin
					second_count_q <= second_count_q + whole_q + SECONDS_WIDTH'(carry_q);
				end
				default: ;
			endcase
		end
	end

	// quotients, delta and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				delta_q <= tick_reading - last_tick_q;
			end
			ST_SETUP: begin
				if (tps_zero) begin
					whole_q <= '0;
					if (tpu_zero) begin
						usec_big_q <= 1'b0;
						usec_lo_q  <= '0;
					end
				end
			end
			ST_DIV1: begin
				if (div_sts.done) begin
					whole_q <= SECONDS_WIDTH'(div_quotient);
					if (tpu_zero) begin
						usec_big_q <= 1'b0;
						usec_lo_q  <= '0;
					end
				end
			end
			ST_DIV2: begin
				if (div_sts.done) begin
					usec_big_q <= |div_quotient[DIVIDEND_WIDTH-1:USEC_LO_WIDTH];
					usec_lo_q  <= div_quotient[USEC_LO_WIDTH-1:0];
				end
			end
			ST_ACC: begin
				carry_q <= usec_over;
			end
			ST_PUB: begin
				if (out_free) begin
					seconds_q      <= second_count_q;
					microseconds_q <= microsecond_count_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign seconds      = seconds_q;
	assign microseconds = microseconds_q;

	// checks
	`ASSERT_NXT(a_one_query, clk, arst_n, in_fire, !in_ready)
	`ASSERT_IMP(a_usec_range, clk, arst_n, out_valid_q, microseconds_q < USEC_LAST + 1'b1)
	`ASSERT_IMP(a_div_owner, clk, arst_n, div_sts.done, state_q == ST_DIV1 || state_q == ST_DIV2)
	`ASSERT_NXT(a_first_latch, clk, arst_n, in_fire && !base_latched_q, state_q == ST_PUB)

endmodule

@@ rtl/tstc_div.sv @@
// ----------------------------------------------------------------------------
// tstc_div
// Restoring radix-2 divider, one quotient bit per cycle. The dividend shifts
// out of the top of a 64-bit register while quotient bits shift in below.
// ----------------------------------------------------------------------------
module tstc_div
	import tstc_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  div_req_t                  req,
	input  logic [DIVIDEND_WIDTH-1:0] dividend,
	input  logic [DIVISOR_WIDTH-1:0]  divisor,
	output div_sts_t                  sts,
	output logic [DIVIDEND_WIDTH-1:0] quotient,
	output logic [DIVISOR_WIDTH-1:0]  remainder
);

	logic [DIVIDEND_WIDTH-1:0] dq_q;
	logic [DIVISOR_WIDTH-1:0]  rem_q;
	logic [DIVISOR_WIDTH-1:0]  dvs_q;
	logic [STEP_CNT_WIDTH-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [DIVISOR_WIDTH+1:0]  trial;
	logic                      fits;

	// trial subtract of the divisor from the shifted partial remainder
	assign trial = {1'b0, rem_q, dq_q[DIVIDEND_WIDTH-1]} - {2'b00, dvs_q};
	assign fits  = ~trial[DIVISOR_WIDTH+1];

	// step counter and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != STEP_CNT_WIDTH'(1));
			done_q <= (cnt_q == STEP_CNT_WIDTH'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath shift registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIVIDEND_WIDTH-2:0], fits};
			rem_q <= fits ? trial[DIVISOR_WIDTH-1:0]
			              : {rem_q[DIVISOR_WIDTH-2:0], dq_q[DIVIDEND_WIDTH-1]};
		end
	end

	assign sts.busy  = busy_q;
	assign sts.done  = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule
